@@ rtl/dir_pkg.sv @@
// shared constants and controller/datapath interface types for the relabeler
`timescale 1ns / 1ps
package dir_pkg;

  // map size and derived widths
  localparam int MAP_DEPTH = 4096;
  localparam int SLOT_W    = $clog2(MAP_DEPTH);
  localparam int COUNT_W   = $clog2(MAP_DEPTH + 1);

  // fixed field widths
  localparam int ID_W  = 31;
  localparam int CMD_W = 2;
  localparam int CFG_W = 2;

  // command codes
  localparam logic [CMD_W-1:0] CMD_MARK    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_COMPACT = 2'd1;
  localparam logic [CMD_W-1:0] CMD_LOOKUP  = 2'd2;
  localparam logic [CMD_W-1:0] CMD_NOP     = 2'd3;

  // register indexes
  localparam logic [CFG_W-1:0] REG_WINDOW_LOW   = 2'd0;
  localparam logic [CFG_W-1:0] REG_WINDOW_HIGH  = 2'd1;
  localparam logic [CFG_W-1:0] REG_LABEL_OFFSET = 2'd2;

  // register reset values
  localparam logic [ID_W-1:0] WINDOW_LOW_RST   = 31'd0;
  localparam logic [ID_W-1:0] WINDOW_HIGH_RST  = 31'd4096;
  localparam logic [ID_W-1:0] LABEL_OFFSET_RST = 31'd0;

  // controller to datapath commands
  typedef struct packed {
    logic clear_en;
    logic load_item;
    logic decode;
    logic mark;
    logic sum;
    logic walk_run;
    logic walk_finish;
    logic push;
  } dir_ctl_t;

  // datapath to controller status
  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic             clear_last;
    logic             walk_done;
    logic             out_free;
  } dir_sts_t;

endpackage

@@ rtl/dense_id_relabeler.sv @@
// top level of the dense identifier relabeler
`timescale 1ns / 1ps
// Maps identifiers in the window [window_low, window_high) onto dense labels.
// After reset the block runs a clearing pass over all MAP_DEPTH (4096) mark
// slots, one slot a cycle; in_ready_o stays low until it ends, while
// register writes are taken throughout. Commands then run one at a time through
// a controller and datapath sharing registered-read memories with one read and
// one write port: a no-op goes from decode straight to its result, a mark adds
// its mark write, a lookup waits for the registered memory read and then forms
// its sum, and a compact walks the window, reading one mark slot per cycle.
// A new word is accepted while an earlier result still waits in the output
// register.
module dense_id_relabeler (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [dir_pkg::CFG_W-1:0]   cfg_index_i,
  input  logic [dir_pkg::ID_W-1:0]    cfg_data_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [dir_pkg::CMD_W-1:0]   cmd_i,
  input  logic [dir_pkg::ID_W-1:0]    node_id_i,
  input  logic                        include_req_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [dir_pkg::ID_W-1:0]    label_o,
  output logic                        hit_o,
  output logic [dir_pkg::COUNT_W-1:0] label_count_o
);

  dir_pkg::dir_ctl_t ctl;
  dir_pkg::dir_sts_t sts;

  // sequencing
  dir_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .ctl_o      (ctl)
  );

  // storage and arithmetic
  dir_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .cmd_i         (cmd_i),
    .node_id_i     (node_id_i),
    .include_req_i (include_req_i),
    .out_ready_i   (out_ready_i),
    .out_valid_o   (out_valid_o),
    .label_o       (label_o),
    .hit_o         (hit_o),
    .label_count_o (label_count_o),
    .ctl_i         (ctl),
    .sts_o         (sts)
  );

endmodule

@@ rtl/dir_ram.sv @@
// generic single write port ram with registered read
`timescale 1ns / 1ps
module dir_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/dir_datapath.sv @@
// datapath: config registers, window check, mark and label memories, walk, result register
`timescale 1ns / 1ps
module dir_datapath (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [dir_pkg::CFG_W-1:0]        cfg_index_i,
  input  logic [dir_pkg::ID_W-1:0]         cfg_data_i,
  input  logic [dir_pkg::CMD_W-1:0]        cmd_i,
  input  logic [dir_pkg::ID_W-1:0]         node_id_i,
  input  logic                             include_req_i,
  input  logic                             out_ready_i,
  output logic                             out_valid_o,
  output logic [dir_pkg::ID_W-1:0]         label_o,
  output logic                             hit_o,
  output logic [dir_pkg::COUNT_W-1:0]      label_count_o,
  input  dir_pkg::dir_ctl_t                ctl_i,
  output dir_pkg::dir_sts_t                sts_o
);

  localparam int SW = dir_pkg::SLOT_W;
  localparam int CW = dir_pkg::COUNT_W;
  localparam int IW = dir_pkg::ID_W;

  // configuration
  logic [IW-1:0] low_q, high_q, offset_q;
  logic [CW-1:0] span_q, span_d;

  // captured word and decode results
  logic [dir_pkg::CMD_W-1:0] cmd_q;
  logic [IW-1:0]             id_q;
  logic                      inc_q;
  logic [SW-1:0]             slot_q;
  logic                      in_win_q;

  // clear and walk state
  logic [SW-1:0] clr_q;
  logic [CW-1:0] wcnt_q, next_q, given_q;
  logic          walk_vld_q;
  logic [SW-1:0] walk_addr_q;

  // pending and delivered result
  logic [IW-1:0] res_label_q;
  logic          res_hit_q;
  logic          out_valid_q;
  logic [IW-1:0] out_label_q;
  logic          out_hit_q;
  logic [CW-1:0] out_cnt_q;

  // memory ports
  logic          mrk_we, mrk_wdata, mrk_rdata;
  logic [SW-1:0] mrk_waddr, mrk_raddr;
  logic          lbl_we;
  logic [SW-1:0] lbl_rdata;

  logic [IW-1:0] diff, ofs;
  logic          in_win;
  logic          walk_issue;
  logic          look_hit;
  logic [IW:0]   sum;

  // effective window span, clamped to the map size
  always_comb begin
    diff   = high_q - low_q;
    span_d = '0;
    if (high_q > low_q) begin
      if (diff > IW'(dir_pkg::MAP_DEPTH)) begin
        span_d = CW'(dir_pkg::MAP_DEPTH);
      end else begin
        span_d = diff[CW-1:0];
      end
    end
  end

  // window membership of the captured identifier
  assign ofs    = id_q - low_q;
  assign in_win = (id_q >= low_q) && (ofs < IW'(span_q));

  // walk issues a read while slots remain
  assign walk_issue = ctl_i.walk_run && (wcnt_q < span_q);

  // marked memory: clear pass or mark write, walk or lookup read
  always_comb begin
    mrk_we    = 1'b0;
    mrk_waddr = slot_q;
    mrk_wdata = 1'b1;
    if (ctl_i.clear_en) begin
      mrk_we    = 1'b1;
      mrk_waddr = clr_q;
      mrk_wdata = 1'b0;
    end else if (ctl_i.mark) begin
      mrk_we = inc_q && in_win_q;
    end
  end

  assign mrk_raddr = ctl_i.walk_run ? wcnt_q[SW-1:0] : slot_q;
  assign lbl_we    = ctl_i.walk_run && walk_vld_q && mrk_rdata;

  dir_ram #(.WIDTH(1), .DEPTH(dir_pkg::MAP_DEPTH)) u_mark_ram (
    .clk_i   (clk_i),
    .we_i    (mrk_we),
    .waddr_i (mrk_waddr),
    .wdata_i (mrk_wdata),
    .raddr_i (mrk_raddr),
    .rdata_o (mrk_rdata)
  );

  dir_ram #(.WIDTH(SW), .DEPTH(dir_pkg::MAP_DEPTH)) u_label_ram (
    .clk_i   (clk_i),
    .we_i    (lbl_we),
    .waddr_i (walk_addr_q),
    .wdata_i (next_q[SW-1:0]),
    .raddr_i (slot_q),
    .rdata_o (lbl_rdata)
  );

  // lookup sum with saturation
  assign look_hit = inc_q && in_win_q && mrk_rdata;
  assign sum      = {1'b0, offset_q} + (IW + 1)'(lbl_rdata);

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_q       <= dir_pkg::WINDOW_LOW_RST;
      high_q      <= dir_pkg::WINDOW_HIGH_RST;
      offset_q    <= dir_pkg::LABEL_OFFSET_RST;
      span_q      <= '0;
      clr_q       <= '0;
      wcnt_q      <= '0;
      next_q      <= '0;
      given_q     <= '0;
      walk_vld_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      span_q <= span_d;
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          dir_pkg::REG_WINDOW_LOW:   low_q    <= cfg_data_i;
          dir_pkg::REG_WINDOW_HIGH:  high_q   <= cfg_data_i;
          dir_pkg::REG_LABEL_OFFSET: offset_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (ctl_i.clear_en) begin
        clr_q <= clr_q + 1'b1;
      end
      // walk counters
      if (ctl_i.decode) begin
        wcnt_q     <= '0;
        next_q     <= '0;
        walk_vld_q <= 1'b0;
      end else if (ctl_i.walk_run) begin
        walk_vld_q <= walk_issue;
        if (walk_issue) begin
          wcnt_q <= wcnt_q + 1'b1;
        end
        if (lbl_we) begin
          next_q <= next_q + 1'b1;
        end
      end
      if (ctl_i.walk_finish) begin
        given_q <= next_q;
      end
      // output valid
      if (ctl_i.push) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (ctl_i.load_item) begin
      cmd_q <= cmd_i;
      id_q  <= node_id_i;
      inc_q <= include_req_i;
    end
    if (ctl_i.decode) begin
      slot_q      <= ofs[SW-1:0];
      in_win_q    <= in_win;
      res_label_q <= '0;
      res_hit_q   <= 1'b0;
    end
    if (ctl_i.walk_run) begin
      walk_addr_q <= wcnt_q[SW-1:0];
    end
    if (ctl_i.sum) begin
      res_hit_q <= look_hit;
      if (!look_hit) begin
        res_label_q <= '0;
      end else if (sum[IW]) begin
        res_label_q <= '1;
      end else begin
        res_label_q <= sum[IW-1:0];
      end
    end
    if (ctl_i.push) begin
      out_label_q <= res_label_q;
      out_hit_q   <= res_hit_q;
      out_cnt_q   <= given_q;
    end
  end

  // status
  assign sts_o.cmd        = cmd_q;
  assign sts_o.clear_last = (clr_q == SW'(dir_pkg::MAP_DEPTH - 1));
  assign sts_o.walk_done  = (wcnt_q >= span_q) && !walk_vld_q;
  assign sts_o.out_free   = !out_valid_q || out_ready_i;

  assign out_valid_o   = out_valid_q;
  assign label_o       = out_label_q;
  assign hit_o         = out_hit_q;
  assign label_count_o = out_cnt_q;

  // a miss always carries a zero label
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_hit_q) |-> (out_label_q == '0))
    else $error("miss result with nonzero label");

  // label count never exceeds the map size
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    given_q <= CW'(dir_pkg::MAP_DEPTH))
    else $error("label count beyond map size");

  // a label write always has a label left to give
  a_label_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lbl_we |-> (next_q < CW'(dir_pkg::MAP_DEPTH)))
    else $error("label write with no label left");

endmodule

@@ rtl/dir_ctrl.sv @@
// controller state machine: clear pass, command sequencing, result hand-off
`timescale 1ns / 1ps
module dir_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  dir_pkg::dir_sts_t sts_i,
  output dir_pkg::dir_ctl_t ctl_o
);

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_DECODE = 3'd2;
  localparam logic [2:0] S_MARK   = 3'd3;
  localparam logic [2:0] S_READ   = 3'd4;
  localparam logic [2:0] S_SUM    = 3'd5;
  localparam logic [2:0] S_WALK   = 3'd6;
  localparam logic [2:0] S_DONE   = 3'd7;

  logic [2:0] state_q, state_d;

  // next state and commands
  always_comb begin
    state_d = state_q;
    ctl_o   = '0;
    unique case (state_q)
      S_CLEAR: begin
        ctl_o.clear_en = 1'b1;
        if (sts_i.clear_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          ctl_o.load_item = 1'b1;
          state_d         = S_DECODE;
        end
      end
      S_DECODE: begin
        ctl_o.decode = 1'b1;
        unique case (sts_i.cmd)
          dir_pkg::CMD_MARK:    state_d = S_MARK;
          dir_pkg::CMD_COMPACT: state_d = S_WALK;
          dir_pkg::CMD_LOOKUP:  state_d = S_READ;
          dir_pkg::CMD_NOP:     state_d = S_DONE;
          default:              state_d = S_DONE;
        endcase
      end
      S_MARK: begin
        ctl_o.mark = 1'b1;
        state_d    = S_DONE;
      end
      S_READ: begin
        state_d = S_SUM;
      end
      S_SUM: begin
        ctl_o.sum = 1'b1;
        state_d   = S_DONE;
      end
      S_WALK: begin
        ctl_o.walk_run = 1'b1;
        if (sts_i.walk_done) begin
          ctl_o.walk_finish = 1'b1;
          state_d           = S_DONE;
        end
      end
      S_DONE: begin
        if (sts_i.out_free) begin
          ctl_o.push = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == S_IDLE);

endmodule

@@ verif/tb_dense_id_relabeler.sv @@
// self-checking testbench for the dense identifier relabeler
`timescale 1ns / 1ps
module tb_dense_id_relabeler;
  import dir_pkg::*;

  // one command word and the result it yields
  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic [ID_W-1:0]  node_id;
    logic             include_req;
  } word_t;

  typedef struct packed {
    logic [ID_W-1:0]    label;
    logic               hit;
    logic [COUNT_W-1:0] count;
  } relabel_t;

  logic               clk;
  logic               rst_n       = 1'b0;
  logic               cfg_we      = 1'b0;
  logic [CFG_W-1:0]   cfg_index   = '0;
  logic [ID_W-1:0]    cfg_data    = '0;
  logic               in_valid    = 1'b0;
  logic               in_ready;
  logic [CMD_W-1:0]   cmd         = '0;
  logic [ID_W-1:0]    node_id     = '0;
  logic               include_req = 1'b0;
  logic               out_valid;
  logic               out_ready   = 1'b0;
  logic [ID_W-1:0]    label;
  logic               hit;
  logic [COUNT_W-1:0] label_count;

  dense_id_relabeler i_dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .cmd_i         (cmd),
    .node_id_i     (node_id),
    .include_req_i (include_req),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .label_o       (label),
    .hit_o         (hit),
    .label_count_o (label_count)
  );

  // predicted map state and register copies
  logic [ID_W-1:0]    win_lo  = WINDOW_LOW_RST;
  logic [ID_W-1:0]    win_hi  = WINDOW_HIGH_RST;
  logic [ID_W-1:0]    lab_off = LABEL_OFFSET_RST;
  bit                 slot_mark [MAP_DEPTH];
  logic [SLOT_W-1:0]  slot_lbl  [MAP_DEPTH];
  logic [COUNT_W-1:0] lbl_total = '0;

  // marked slots not yet labeled by a compact, seen from the generator
  bit                 unlabeled [MAP_DEPTH];
  logic [ID_W-1:0]    mark_ids[$];

  word_t              pending_words[$];
  relabel_t           expected_labels[$];
  word_t              cur_word;

  int                 send_gap_pct = 0;
  int                 rx_stall_pct = 0;
  bit                 hold_go      = 1'b0;
  logic               rx_hold      = 1'b0;
  int                 err_cnt      = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // number of live slots in the window, cut to the map size
  function automatic int unsigned span_of(input logic [ID_W-1:0] lo,
                                          input logic [ID_W-1:0] hi);
    int unsigned d;
    if (hi <= lo) return 0;
    d = hi - lo;
    return (d > MAP_DEPTH) ? MAP_DEPTH : d;
  endfunction

  function automatic bit in_window(input logic [ID_W-1:0] id, output int unsigned slot);
    int unsigned d;
    slot = 0;
    if (id < win_lo) return 1'b0;
    d = id - win_lo;
    if (d >= span_of(win_lo, win_hi)) return 1'b0;
    slot = d;
    return 1'b1;
  endfunction

  function automatic void note_error(input string msg);
    err_cnt++;
    if (err_cnt <= 10) $display("%0t: %s", $time, msg);
  endfunction

  // expected result of one accepted word, updating the map copy
  task automatic relabel_word(input word_t w);
    relabel_t           r;
    int unsigned        span;
    int unsigned        slot;
    int unsigned        i;
    bit                 inwin;
    logic [COUNT_W-1:0] next;
    logic [ID_W:0]      sum;
    r     = '0;
    span  = span_of(win_lo, win_hi);
    inwin = in_window(w.node_id, slot);
    case (w.cmd)
      CMD_MARK: begin
        if (w.include_req && inwin) slot_mark[slot] = 1'b1;
      end
      CMD_COMPACT: begin
        next = '0;
        for (i = 0; i < span; i++) begin
          if (slot_mark[i]) begin
            slot_lbl[i] = next[SLOT_W-1:0];
            next++;
          end
        end
        lbl_total = next;
      end
      CMD_LOOKUP: begin
        if (w.include_req && inwin && slot_mark[slot]) begin
          sum = {{(ID_W + 1 - SLOT_W){1'b0}}, slot_lbl[slot]} + {1'b0, lab_off};
          // saturate at the largest label
          r.label = sum[ID_W] ? '1 : sum[ID_W-1:0];
          r.hit   = 1'b1;
        end
      end
      default: ;
    endcase
    r.count = lbl_total;
    expected_labels.push_back(r);
  endtask

  // driver: offers the next pending word, holds it until accepted
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) relabel_word(cur_word);
      if (!in_valid || in_ready) begin
        if (pending_words.size() > 0 && $urandom_range(99) >= send_gap_pct) begin
          cur_word     = pending_words.pop_front();
          in_valid    <= 1'b1;
          cmd         <= cur_word.cmd;
          node_id     <= cur_word.node_id;
          include_req <= cur_word.include_req;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: compares each result word with the oldest prediction
  always @(posedge clk or negedge rst_n) begin : monitor
    relabel_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_labels.size() == 0) begin
          note_error($sformatf("result with nothing expected: label %0d hit %0d count %0d",
                               label, hit, label_count));
        end else begin
          want = expected_labels.pop_front();
          if (label !== want.label || hit !== want.hit || label_count !== want.count)
            note_error($sformatf({"mismatch: expected label %0d hit %0d count %0d,",
                                  " got label %0d hit %0d count %0d"},
                                 want.label, want.hit, want.count,
                                 label, hit, label_count));
        end
      end
      out_ready <= !rx_hold && ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // long receiver hold-off while the sender keeps offering
  initial begin
    wait (hold_go);
    @(posedge clk);
    rx_hold <= 1'b1;
    repeat (300) @(posedge clk);
    rx_hold <= 1'b0;
  end

  initial begin
    #20_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  task automatic write_reg(input logic [CFG_W-1:0] idx, input logic [ID_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    case (idx)
      REG_WINDOW_LOW:   win_lo  = val;
      REG_WINDOW_HIGH:  win_hi  = val;
      REG_LABEL_OFFSET: lab_off = val;
      default: ;
    endcase
  endtask

  task automatic set_window(input logic [ID_W-1:0] lo, input logic [ID_W-1:0] hi,
                            input logic [ID_W-1:0] off);
    write_reg(REG_WINDOW_LOW, lo);
    write_reg(REG_WINDOW_HIGH, hi);
    write_reg(REG_LABEL_OFFSET, off);
  endtask

  // sender pause until every word is through and every result is back
  task automatic wait_idle();
    @(negedge clk);
    while (pending_words.size() != 0 || in_valid || expected_labels.size() != 0)
      @(negedge clk);
  endtask

  // queue a word; a lookup that would read a never labeled slot is queued with its include flag cleared
  task automatic queue_word(input logic [CMD_W-1:0] c, input logic [ID_W-1:0] id,
                            input logic inc);
    int unsigned span;
    int unsigned slot;
    int unsigned i;
    bit          inwin;
    word_t       w;
    span  = span_of(win_lo, win_hi);
    inwin = in_window(id, slot);
    if (c == CMD_MARK && inc && inwin) unlabeled[slot] = 1'b1;
    if (c == CMD_COMPACT)
      for (i = 0; i < span; i++) unlabeled[i] = 1'b0;
    if (c == CMD_LOOKUP && inc && inwin && unlabeled[slot]) inc = 1'b0;
    w.cmd         = c;
    w.node_id     = id;
    w.include_req = inc;
    pending_words.push_back(w);
  endtask

  // identifiers mostly inside the window, some at its edges, some anywhere
  function automatic logic [ID_W-1:0] pick_id();
    int unsigned span;
    int unsigned r;
    int unsigned v;
    span = span_of(win_lo, win_hi);
    r    = $urandom_range(99);
    if (r < 70 && span > 0) v = win_lo + $urandom_range(0, span - 1);
    else if (r < 80)        v = win_lo + span + $urandom_range(0, 2);
    else if (r < 85)        v = win_lo - 1;
    else                    v = $urandom();
    return ID_W'(v);
  endfunction

  // mark bursts, a compact, then lookups mixed with stray commands
  task automatic queue_phase(input int n);
    int               made;
    int               k;
    int               burst;
    int unsigned      r;
    logic [ID_W-1:0]  id;
    logic [CMD_W-1:0] c;
    made = 0;
    mark_ids.delete();
    while (made < n) begin
      burst = $urandom_range(2, 10);
      for (k = 0; k < burst; k++) begin
        id = pick_id();
        mark_ids.push_back(id);
        queue_word(CMD_MARK, id, $urandom_range(99) < 90);
      end
      made += burst;
      // now and then a sequence goes on without its compact
      if ($urandom_range(99) < 90) begin
        queue_word(CMD_COMPACT, pick_id(), $urandom_range(1) == 1);
        made++;
      end
      burst = $urandom_range(3, 12);
      for (k = 0; k < burst; k++) begin
        r = $urandom_range(99);
        c = (r < 15) ? CMD_MARK : (r < 23) ? CMD_NOP : (r < 26) ? CMD_COMPACT : CMD_LOOKUP;
        if (c == CMD_LOOKUP && mark_ids.size() > 0 && $urandom_range(99) < 60)
          id = mark_ids[$urandom_range(0, mark_ids.size() - 1)];
        else
          id = pick_id();
        queue_word(c, id, $urandom_range(99) < 90);
      end
      made += burst;
    end
  endtask

  initial begin : stimulus
    int              p;
    logic [ID_W-1:0] lo;
    logic [ID_W-1:0] hi;
    logic [ID_W-1:0] off;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // default window: edges, exclusion, out of range, no-op, repeated compact
    queue_word(CMD_LOOKUP, 31'd5, 1'b1);
    queue_word(CMD_MARK, 31'd0, 1'b1);
    queue_word(CMD_MARK, 31'd4095, 1'b1);
    queue_word(CMD_MARK, 31'd4096, 1'b1);
    queue_word(CMD_MARK, 31'd7, 1'b0);
    queue_word(CMD_MARK, 31'h7FFFFFFF, 1'b1);
    queue_word(CMD_NOP, 31'h7FFFFFFF, 1'b1);
    queue_word(CMD_COMPACT, 31'd0, 1'b0);
    queue_word(CMD_LOOKUP, 31'd0, 1'b1);
    queue_word(CMD_LOOKUP, 31'd4095, 1'b1);
    queue_word(CMD_LOOKUP, 31'd4095, 1'b0);
    queue_word(CMD_LOOKUP, 31'd4096, 1'b1);
    queue_word(CMD_LOOKUP, 31'd7, 1'b1);
    queue_word(CMD_MARK, 31'd7, 1'b1);
    queue_word(CMD_COMPACT, 31'h7FFFFFFF, 1'b1);
    queue_word(CMD_LOOKUP, 31'd7, 1'b1);
    wait_idle();

    // empty window
    set_window(31'd100, 31'd50, 31'd0);
    queue_word(CMD_MARK, 31'd120, 1'b1);
    queue_word(CMD_LOOKUP, 31'd100, 1'b1);
    queue_word(CMD_COMPACT, 31'd0, 1'b1);
    wait_idle();

    // largest offset, labels saturate
    set_window(31'd0, 31'd4096, 31'h7FFFFFFF);
    queue_word(CMD_LOOKUP, 31'd0, 1'b1);
    queue_word(CMD_LOOKUP, 31'd4095, 1'b1);
    wait_idle();

    // window moved to the top of the id range, old marks read by position
    set_window(31'h7FFFF000, 31'h7FFFFFFF, 31'd5);
    queue_word(CMD_LOOKUP, 31'h7FFFF000, 1'b1);
    queue_word(CMD_LOOKUP, 31'h7FFFF007, 1'b1);
    queue_word(CMD_LOOKUP, 31'h7FFFFFFF, 1'b1);
    wait_idle();

    // oversized window cut to the map size
    set_window(31'd10, 31'h7FFFFFFF, 31'd0);
    queue_word(CMD_LOOKUP, 31'd10, 1'b1);
    queue_word(CMD_LOOKUP, 31'd4106, 1'b1);
    wait_idle();

    // random phases over several windows and handshake patterns
    for (p = 0; p < 10; p++) begin
      lo  = ID_W'($urandom_range(64, 32'h7FFFEC00));
      hi  = lo + ID_W'($urandom_range(16, 300));
      off = ID_W'($urandom());
      case (p)
        0, 4: begin
          lo  = '0;
          hi  = 31'd64;
          off = '0;
        end
        2: off = 31'h7FFFFFFF - ID_W'($urandom_range(0, 100));
        5: hi = 31'h7FFFFFFF;
        6: hi = lo - ID_W'($urandom_range(0, 50));
        7: begin
          lo  = 31'h7FFFFFFF - 31'd200;
          hi  = 31'h7FFFFFFF;
          off = '0;
        end
        8: begin
          lo  = '0;
          hi  = '0;
          off = 31'h7FFFFFFF;
        end
        default: ;
      endcase
      set_window(lo, hi, off);
      case (p % 4)
        0: begin send_gap_pct = 0;  rx_stall_pct = 0;  end
        1: begin send_gap_pct = 71; rx_stall_pct = 0;  end
        2: begin send_gap_pct = 0;  rx_stall_pct = 71; end
        default: begin send_gap_pct = 30; rx_stall_pct = 30; end
      endcase
      if (p == 4) hold_go = 1'b1;
      queue_phase(45);
      wait_idle();
    end

    repeat (20) @(posedge clk);
    if (err_cnt == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
